>>> design/mrr_pkg.sv
package mrr_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int MAX_COUNT   = (FRAME_BYTES - 5) / 2;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [0:0] CFG_DEV_ADDR = 1'd0;
  localparam logic [0:0] CFG_TIMEOUT  = 1'd1;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  DEV_ADDR_RESET    = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd150;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] payload;
    logic [6:0]  word_index;
    logic [1:0]  status;
    logic        tx_last;
  } mrr_res_t;

  typedef struct packed {
    logic     vld;
    mrr_res_t res;
  } mrr_rsp_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [6:0] clamp_count(input logic [6:0] cnt);
    logic [6:0] m;
    m = 7'(MAX_COUNT);
    return (cnt > m) ? m : cnt;
  endfunction

endpackage

>>> design/mrr_in_if.sv
interface mrr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] start_address;
  logic [6:0]  reg_count;
  logic [7:0]  rx_byte;

  modport source (output valid, output req_type, output start_address,
                  output reg_count, output rx_byte, input ready);
  modport sink (input valid, input req_type, input start_address,
                input reg_count, input rx_byte, output ready);
endinterface

>>> design/mrr_out_if.sv
interface mrr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] payload;
  logic [6:0]  word_index;
  logic [1:0]  status;
  logic        tx_last;

  modport source (output valid, output kind, output payload, output word_index,
                  output status, output tx_last, input ready);
  modport sink (input valid, input kind, input payload, input word_index,
                input status, input tx_last, output ready);
endinterface

>>> design/mrr_reply.sv
module mrr_reply (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          req_type,
  input  logic [6:0]          reg_count,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         timeout_ticks,
  output mrr_pkg::mrr_rsp_t   rsp
);

  logic        waiting_r, waiting_nxt;
  logic [7:0]  rcv_cnt_r, rcv_cnt_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  body;
  logic [7:0]  widx;
  logic [6:0]  cnt_c;

  always_comb begin
    waiting_nxt   = waiting_r;
    rcv_cnt_nxt   = rcv_cnt_r;
    frame_len_nxt = frame_len_r;
    crc_nxt       = crc_r;
    ticks_nxt     = ticks_r;
    hi_nxt        = hi_r;
    crc_lo_nxt    = crc_lo_r;
    rsp           = '0;
    body          = frame_len_r - 8'd2;
    widx          = (rcv_cnt_r - 8'd4) >> 1;
    cnt_c         = mrr_pkg::clamp_count(reg_count);
    if (accept) begin
      unique case (req_type)
        mrr_pkg::REQ_START: begin
          waiting_nxt   = 1'b1;
          rcv_cnt_nxt   = '0;
          frame_len_nxt = {cnt_c, 1'b0} + 8'd5;
          crc_nxt       = mrr_pkg::CRC_INIT;
          ticks_nxt     = '0;
          hi_nxt        = '0;
          crc_lo_nxt    = '0;
        end
        mrr_pkg::REQ_BYTE: begin
          if (waiting_r) begin
            if (rcv_cnt_r < body) begin
              crc_nxt = mrr_pkg::crc_byte(crc_r, rx_byte);
              if (rcv_cnt_r >= 8'd3) begin
                if (rcv_cnt_r[0]) begin
                  hi_nxt = rx_byte;
                end else begin
                  rsp.vld            = 1'b1;
                  rsp.res.kind       = mrr_pkg::KIND_WORD;
                  rsp.res.payload    = {hi_r, rx_byte};
                  rsp.res.word_index = widx[6:0];
                end
              end
            end else if (rcv_cnt_r == body) begin
              crc_lo_nxt = rx_byte;
            end else begin
              rsp.vld          = 1'b1;
              rsp.res.kind     = mrr_pkg::KIND_STATUS;
              rsp.res.status   = ({rx_byte, crc_lo_r} == crc_r) ? mrr_pkg::ST_OK
                                                                : mrr_pkg::ST_CRC;
              waiting_nxt      = 1'b0;
            end
            rcv_cnt_nxt = rcv_cnt_r + 8'd1;
          end
        end
        mrr_pkg::REQ_TICK: begin
          if (waiting_r) begin
            ticks_nxt = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
            if (ticks_nxt >= timeout_ticks) begin
              rsp.vld        = 1'b1;
              rsp.res.kind   = mrr_pkg::KIND_STATUS;
              rsp.res.status = mrr_pkg::ST_TIMEOUT;
              waiting_nxt    = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r   <= 1'b0;
      rcv_cnt_r   <= '0;
      frame_len_r <= '0;
      crc_r       <= mrr_pkg::CRC_INIT;
      ticks_r     <= '0;
      hi_r        <= '0;
      crc_lo_r    <= '0;
    end else begin
      waiting_r   <= waiting_nxt;
      rcv_cnt_r   <= rcv_cnt_nxt;
      frame_len_r <= frame_len_nxt;
      crc_r       <= crc_nxt;
      ticks_r     <= ticks_nxt;
      hi_r        <= hi_nxt;
      crc_lo_r    <= crc_lo_nxt;
    end
  end

  // reply position never passes the trailer while waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    waiting_r |-> (rcv_cnt_r <= frame_len_r - 8'd1))
    else $error("reply position past frame");

  // any status result ends the transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.vld && rsp.res.kind == mrr_pkg::KIND_STATUS) |=> !waiting_r)
    else $error("status without going idle");

  // results only come from a running transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> (waiting_r && accept))
    else $error("result while idle");

endmodule

>>> design/modbus_read_registers_master.sv
// Modbus RTU master, function 3 (read holding registers).
// in_ch takes words of three types: a start request (start_address, reg_count),
// a received line byte (rx_byte) and a one millisecond tick. out_ch gives
// transmit bytes, register words and a final transaction status.
// A start produces the 8 request bytes (address, 0x03, start, count, CRC low
// first), one per cycle on out_ch while out_ch is ready, tx_last on the eighth;
// in_ch is held off until the last one is loaded.
// Received bytes and ticks are registered into the output: any result appears
// on out_ch in the cycle after the word is accepted, and the next word is taken
// in the same cycle as long as the output register is empty or being drained.
// Register words appear as their second byte arrives; commit them only after
// a status of ok. A bad reply CRC gives crc error, running out of ticks gives
// timeout.
// cfg_index 0 sets the device address, 1 the timeout in ticks; write only
// while idle.
// Reset: device address 1, timeout 150, master idle, output empty.
// When out_ch stalls, the result stays in the output register and in_ch
// deasserts ready until it is taken.
module modbus_read_registers_master (
  input  logic        clk,
  input  logic        rst_n,
  mrr_in_if.sink      in_ch,
  mrr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [7:0]        dev_addr_r;
  logic [15:0]       timeout_r;
  logic              out_valid_r, out_valid_nxt;
  mrr_pkg::mrr_res_t out_r, out_nxt;
  logic              tx_pend_r, tx_pend_nxt;
  logic [2:0]        tx_idx_r, tx_idx_nxt;
  logic [15:0]       tx_crc_r, tx_crc_nxt;
  logic [15:0]       tx_addr_r, tx_addr_nxt;
  logic [6:0]        tx_cnt_r, tx_cnt_nxt;
  logic [7:0]        tx_byte;
  logic              out_free;
  logic              in_fire;
  mrr_pkg::mrr_rsp_t rsp;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !tx_pend_r && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  mrr_reply u_reply (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_fire),
    .req_type      (in_ch.req_type),
    .reg_count     (in_ch.reg_count),
    .rx_byte       (in_ch.rx_byte),
    .timeout_ticks (timeout_r),
    .rsp           (rsp)
  );

  always_comb begin
    unique case (tx_idx_r)
      3'd0:    tx_byte = dev_addr_r;
      3'd1:    tx_byte = mrr_pkg::FUNC_READ_HOLDING;
      3'd2:    tx_byte = tx_addr_r[15:8];
      3'd3:    tx_byte = tx_addr_r[7:0];
      3'd4:    tx_byte = 8'h00;
      3'd5:    tx_byte = {1'b0, tx_cnt_r};
      3'd6:    tx_byte = tx_crc_r[7:0];
      3'd7:    tx_byte = tx_crc_r[15:8];
      default: tx_byte = 8'h00;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    tx_pend_nxt   = tx_pend_r;
    tx_idx_nxt    = tx_idx_r;
    tx_crc_nxt    = tx_crc_r;
    tx_addr_nxt   = tx_addr_r;
    tx_cnt_nxt    = tx_cnt_r;
    if (in_fire && in_ch.req_type == mrr_pkg::REQ_START) begin
      out_valid_nxt   = 1'b1;
      out_nxt         = '0;
      out_nxt.kind    = mrr_pkg::KIND_TX;
      out_nxt.payload = {8'h00, dev_addr_r};
      tx_pend_nxt     = 1'b1;
      tx_idx_nxt      = 3'd1;
      tx_crc_nxt      = mrr_pkg::crc_byte(mrr_pkg::CRC_INIT, dev_addr_r);
      tx_addr_nxt     = in_ch.start_address;
      tx_cnt_nxt      = mrr_pkg::clamp_count(in_ch.reg_count);
    end else if (rsp.vld) begin
      out_valid_nxt = 1'b1;
      out_nxt       = rsp.res;
    end else if (tx_pend_r && out_free) begin
      out_valid_nxt   = 1'b1;
      out_nxt         = '0;
      out_nxt.kind    = mrr_pkg::KIND_TX;
      out_nxt.payload = {8'h00, tx_byte};
      out_nxt.tx_last = (tx_idx_r == 3'd7);
      if (tx_idx_r < 3'd6) begin
        tx_crc_nxt = mrr_pkg::crc_byte(tx_crc_r, tx_byte);
      end
      tx_idx_nxt = tx_idx_r + 3'd1;
      if (tx_idx_r == 3'd7) begin
        tx_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= mrr_pkg::DEV_ADDR_RESET;
      timeout_r   <= mrr_pkg::TIMEOUT_RESET;
      out_valid_r <= 1'b0;
      tx_pend_r   <= 1'b0;
      tx_idx_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mrr_pkg::CFG_DEV_ADDR: dev_addr_r <= cfg_wdata[7:0];
          mrr_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      out_valid_r <= out_valid_nxt;
      tx_pend_r   <= tx_pend_nxt;
      tx_idx_r    <= tx_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    tx_crc_r  <= tx_crc_nxt;
    tx_addr_r <= tx_addr_nxt;
    tx_cnt_r  <= tx_cnt_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.payload    = out_r.payload;
  assign out_ch.word_index = out_r.word_index;
  assign out_ch.status     = out_r.status;
  assign out_ch.tx_last    = out_r.tx_last;

  // while request bytes remain, the output holds a request byte
  assert property (@(posedge clk) disable iff (!rst_n)
    tx_pend_r |-> (out_valid_r && out_r.kind == mrr_pkg::KIND_TX))
    else $error("request sequence lost its output");

  // tx_last marks only the closing request byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.tx_last) |-> (out_r.kind == mrr_pkg::KIND_TX && !tx_pend_r))
    else $error("tx_last out of place");

  // a start loads the device address as the first request byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.req_type == mrr_pkg::REQ_START) |=>
      (out_valid_r && out_r.payload == {8'h00, dev_addr_r} && tx_idx_r == 3'd1))
    else $error("request did not open with device address");

endmodule
